// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- src/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared constants, codes and types of the sorted region table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srt_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 32;
    localparam int SLOT_W      = 6;
    localparam int ENT_W       = 7;
    localparam int STATUS_W    = 3;
    localparam int CMD_W       = 2;
    localparam int GROUP       = 8;
    localparam int NUM_GROUPS  = (MAX_REGIONS + GROUP - 1) / GROUP;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_VERIFY = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_KERNEL    = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_FULL      = 3'd4,
        ST_MISMATCH  = 3'd5
    } status_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              cmp;
        logic              ins;
        logic              rem;
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] new_last;
    } cell_ctl_t;

    // floor match picked out of the cell row
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] last;
    } sel_t;

endpackage

// ----- src/srt_cell.sv -----
// ----------------------------------------------------------------------------
// srt_cell
// One table entry: compares its start against the key and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  srt_pkg::cell_ctl_t        ctl,
    input  logic                      in_use,
    input  logic                      prev_hit,
    input  logic [srt_pkg::ADDR_W-1:0] prev_start,
    input  logic [srt_pkg::ADDR_W-1:0] prev_last,
    input  logic                      next_hit,
    input  logic [srt_pkg::ADDR_W-1:0] next_start,
    input  logic [srt_pkg::ADDR_W-1:0] next_last,
    output logic                      hit_reg,
    output logic [srt_pkg::ADDR_W-1:0] start_reg,
    output logic [srt_pkg::ADDR_W-1:0] last_reg
);

    logic                       hit_next;
    logic [srt_pkg::ADDR_W-1:0] start_next;
    logic [srt_pkg::ADDR_W-1:0] last_next;

    always_comb
    begin
        hit_next   = hit_reg;
        start_next = start_reg;
        last_next  = last_reg;
        if (ctl.cmp)
        begin
            hit_next = in_use && (start_reg <= ctl.key);
        end
        if (ctl.ins && !hit_reg)
        begin
            // first cell past the floor takes the new region
            if (prev_hit)
            begin
                start_next = ctl.key;
                last_next  = ctl.new_last;
            end
            else
            begin
                start_next = prev_start;
                last_next  = prev_last;
            end
        end
        if (ctl.rem && !next_hit)
        begin
            start_next = next_start;
            last_next  = next_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        last_reg  <= last_next;
    end

endmodule

// ----- src/srt_select.sv -----
// ----------------------------------------------------------------------------
// srt_select
// Two-level registered tree that picks the floor entry out of the cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srt_select (
    input  logic                       clk,
    input  logic [srt_pkg::MAX_REGIONS-1:0] hit,
    input  logic [srt_pkg::ADDR_W-1:0] starts [srt_pkg::MAX_REGIONS],
    input  logic [srt_pkg::ADDR_W-1:0] lasts  [srt_pkg::MAX_REGIONS],
    output srt_pkg::sel_t              sel_reg
);

    logic [srt_pkg::MAX_REGIONS-1:0] bnd;
    logic                       grp_any_next   [srt_pkg::NUM_GROUPS];
    logic [srt_pkg::IDX_W-1:0]  grp_idx_next   [srt_pkg::NUM_GROUPS];
    logic [srt_pkg::ADDR_W-1:0] grp_start_next [srt_pkg::NUM_GROUPS];
    logic [srt_pkg::ADDR_W-1:0] grp_last_next  [srt_pkg::NUM_GROUPS];
    logic                       grp_any_reg    [srt_pkg::NUM_GROUPS];
    logic [srt_pkg::IDX_W-1:0]  grp_idx_reg    [srt_pkg::NUM_GROUPS];
    logic [srt_pkg::ADDR_W-1:0] grp_start_reg  [srt_pkg::NUM_GROUPS];
    logic [srt_pkg::ADDR_W-1:0] grp_last_reg   [srt_pkg::NUM_GROUPS];
    srt_pkg::sel_t              sel_next;

    // hits form a prefix; the floor is the last hit
    assign bnd = hit & ~(hit >> 1);

    always_comb
    begin
        for (int g = 0; g < srt_pkg::NUM_GROUPS; g++)
        begin
            grp_any_next[g]   = 1'b0;
            grp_idx_next[g]   = '0;
            grp_start_next[g] = '0;
            grp_last_next[g]  = '0;
            for (int j = 0; j < srt_pkg::GROUP; j++)
            begin
                if (g * srt_pkg::GROUP + j < srt_pkg::MAX_REGIONS)
                begin
                    if (bnd[g * srt_pkg::GROUP + j])
                    begin
                        grp_any_next[g]   = 1'b1;
                        grp_idx_next[g]   = grp_idx_next[g]
                            | srt_pkg::IDX_W'(g * srt_pkg::GROUP + j);
                        grp_start_next[g] = grp_start_next[g]
                            | starts[g * srt_pkg::GROUP + j];
                        grp_last_next[g]  = grp_last_next[g]
                            | lasts[g * srt_pkg::GROUP + j];
                    end
                end
            end
        end
    end

    always_comb
    begin
        sel_next = '0;
        for (int g = 0; g < srt_pkg::NUM_GROUPS; g++)
        begin
            if (grp_any_reg[g])
            begin
                sel_next.found = 1'b1;
                sel_next.idx   = sel_next.idx | grp_idx_reg[g];
                sel_next.start = sel_next.start | grp_start_reg[g];
                sel_next.last  = sel_next.last | grp_last_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < srt_pkg::NUM_GROUPS; g++)
        begin
            grp_any_reg[g]   <= grp_any_next[g];
            grp_idx_reg[g]   <= grp_idx_next[g];
            grp_start_reg[g] <= grp_start_next[g];
            grp_last_reg[g]  <= grp_last_next[g];
        end
        sel_reg <= sel_next;
    end

endmodule

// ----- src/sorted_region_table.sv -----
// ----------------------------------------------------------------------------
// sorted_region_table: sorted region table with floor search, verify, insert, remove
// Steps: compare, two tree levels, apply; apply waits while a result is still held on the output.
// A new request is taken only in idle, once the previous one has been applied.
// Reset: entry count and first_user_address cleared at once; entries need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_region_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [srt_pkg::ADDR_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [srt_pkg::CMD_W-1:0]    cmd,
    input  logic [srt_pkg::ADDR_W-1:0]   address,
    input  logic [srt_pkg::ADDR_W-1:0]   size,
    input  logic [srt_pkg::ADDR_W-1:0]   region_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [srt_pkg::STATUS_W-1:0] status,
    output logic [srt_pkg::SLOT_W-1:0]   slot,
    output logic [srt_pkg::ADDR_W-1:0]   found_start,
    output logic [srt_pkg::ADDR_W-1:0]   found_last,
    output logic [srt_pkg::ENT_W-1:0]    entries
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_GRP  = 5'b00100,
        S_SEL  = 5'b01000,
        S_EXEC = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    srt_pkg::cmd_t              cmd_reg;
    logic [srt_pkg::ADDR_W-1:0] addr_reg, size_reg, rlast_reg, end_reg, end_next;
    logic [srt_pkg::ADDR_W-1:0] first_user_reg;
    logic [srt_pkg::CNT_W-1:0]  count_reg, count_next;

    logic                       out_valid_reg, out_valid_next;
    srt_pkg::status_t           status_reg, status_next;
    logic [srt_pkg::IDX_W-1:0]  slot_reg, slot_next;
    logic [srt_pkg::ADDR_W-1:0] fstart_reg, fstart_next, flast_reg, flast_next;

    srt_pkg::cell_ctl_t         ctl;
    srt_pkg::sel_t              sel;
    logic [srt_pkg::MAX_REGIONS-1:0] hit_vec;
    logic [srt_pkg::ADDR_W-1:0] start_arr [srt_pkg::MAX_REGIONS];
    logic [srt_pkg::ADDR_W-1:0] last_arr  [srt_pkg::MAX_REGIONS];

    logic accept, go, exec_go, full, match;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign go          = !out_valid_reg || out_ready;
    assign exec_go     = (state_reg == S_EXEC) && go;
    assign full        = (count_reg >= srt_pkg::CNT_W'(srt_pkg::MAX_REGIONS));
    assign match       = (sel.start == addr_reg) && (sel.last == rlast_reg);
    assign end_next    = addr_reg + size_reg - srt_pkg::ADDR_W'(1);

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot        = srt_pkg::SLOT_W'(slot_reg);
    assign found_start = fstart_reg;
    assign found_last  = flast_reg;
    assign entries     = srt_pkg::ENT_W'(count_reg);

    always_comb
    begin
        ctl.cmp      = (state_reg == S_CMP);
        ctl.ins      = exec_go && (cmd_reg == srt_pkg::CMD_INSERT) && !full;
        ctl.rem      = exec_go && (cmd_reg == srt_pkg::CMD_REMOVE) && sel.found && match;
        ctl.key      = addr_reg;
        ctl.new_last = rlast_reg;
    end

    genvar k;
    generate
        for (k = 0; k < srt_pkg::MAX_REGIONS; k++)
        begin : g_cell
            logic                       p_hit, n_hit;
            logic [srt_pkg::ADDR_W-1:0] p_start, p_last, n_start, n_last;

            if (k == 0)
            begin : g_first
                assign p_hit   = 1'b1;
                assign p_start = '0;
                assign p_last  = '0;
            end
            else
            begin : g_mid
                assign p_hit   = hit_vec[k-1];
                assign p_start = start_arr[k-1];
                assign p_last  = last_arr[k-1];
            end

            if (k == srt_pkg::MAX_REGIONS - 1)
            begin : g_end
                assign n_hit   = 1'b0;
                assign n_start = start_arr[k];
                assign n_last  = last_arr[k];
            end
            else
            begin : g_inner
                assign n_hit   = hit_vec[k+1];
                assign n_start = start_arr[k+1];
                assign n_last  = last_arr[k+1];
            end

            srt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .in_use     (srt_pkg::CNT_W'(k) < count_reg),
                .prev_hit   (p_hit),
                .prev_start (p_start),
                .prev_last  (p_last),
                .next_hit   (n_hit),
                .next_start (n_start),
                .next_last  (n_last),
                .hit_reg    (hit_vec[k]),
                .start_reg  (start_arr[k]),
                .last_reg   (last_arr[k])
            );
        end
    endgenerate

    srt_select u_select (
        .clk     (clk),
        .hit     (hit_vec),
        .starts  (start_arr),
        .lasts   (last_arr),
        .sel_reg (sel)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CMP;
            S_CMP:   state_next = S_GRP;
            S_GRP:   state_next = S_SEL;
            S_SEL:   state_next = S_EXEC;
            S_EXEC:  if (go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        status_next    = status_reg;
        slot_next      = slot_reg;
        fstart_next    = fstart_reg;
        flast_next     = flast_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (exec_go)
        begin
            out_valid_next = 1'b1;
            status_next    = srt_pkg::ST_OK;
            slot_next      = sel.idx;
            fstart_next    = sel.start;
            flast_next     = sel.last;
            case (cmd_reg)
                srt_pkg::CMD_LOOKUP:
                begin
                    if (!sel.found)
                    begin
                        status_next = srt_pkg::ST_NOT_FOUND;
                    end
                end
                srt_pkg::CMD_VERIFY:
                begin
                    if (addr_reg < first_user_reg)
                    begin
                        status_next = srt_pkg::ST_KERNEL;
                        slot_next   = '0;
                        fstart_next = '0;
                        flast_next  = '0;
                    end
                    else if (!sel.found)
                    begin
                        status_next = srt_pkg::ST_NOT_FOUND;
                    end
                    else if (end_reg > sel.last)
                    begin
                        status_next = srt_pkg::ST_NO_FIT;
                    end
                end
                srt_pkg::CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = srt_pkg::ST_FULL;
                        slot_next   = '0;
                        fstart_next = '0;
                        flast_next  = '0;
                    end
                    else
                    begin
                        slot_next   = sel.found ? sel.idx + srt_pkg::IDX_W'(1) : '0;
                        fstart_next = addr_reg;
                        flast_next  = rlast_reg;
                        count_next  = count_reg + srt_pkg::CNT_W'(1);
                    end
                end
                srt_pkg::CMD_REMOVE:
                begin
                    if (!sel.found)
                    begin
                        status_next = srt_pkg::ST_NOT_FOUND;
                    end
                    else if (!match)
                    begin
                        status_next = srt_pkg::ST_MISMATCH;
                    end
                    else
                    begin
                        count_next = count_reg - srt_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = srt_pkg::ST_OK;
                end
            endcase
            // not-found carries a zero region
            if (status_next == srt_pkg::ST_NOT_FOUND)
            begin
                slot_next   = '0;
                fstart_next = '0;
                flast_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            first_user_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                first_user_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= srt_pkg::cmd_t'(cmd);
            addr_reg  <= address;
            size_reg  <= size;
            rlast_reg <= region_last;
        end
        if (state_reg == S_CMP)
        begin
            end_reg <= end_next;
        end
        status_reg <= status_next;
        slot_reg   <= slot_next;
        fstart_reg <= fstart_next;
        flast_reg  <= flast_next;
    end

endmodule

// ----- src/srt_checker.sv -----
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks of the sorted region table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [srt_pkg::STATUS_W-1:0] status,
    input logic [srt_pkg::SLOT_W-1:0]   slot,
    input logic [srt_pkg::ADDR_W-1:0]   found_start,
    input logic [srt_pkg::ADDR_W-1:0]   found_last,
    input logic [srt_pkg::ENT_W-1:0]    entries
);

    logic nf_out;
    logic nf_zero;
    logic full_out;
    logic at_depth;
    logic in_depth;

    assign nf_out   = out_valid && (status == srt_pkg::ST_NOT_FOUND);
    assign nf_zero  = (slot == '0) && (found_start == '0) && (found_last == '0);
    assign full_out = out_valid && (status == srt_pkg::ST_FULL);
    assign at_depth = (entries == srt_pkg::ENT_W'(srt_pkg::MAX_REGIONS));
    assign in_depth = (entries <= srt_pkg::ENT_W'(srt_pkg::MAX_REGIONS));

    // result holds until taken
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // one request at a time: busy right after a request is taken
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // count does not exceed the table depth while a result is valid
    `ASSERT_IMPLY(a_entries_max, clk, rst_n, out_valid, in_depth)

    // missing region reports a zero slot and region
    `ASSERT_IMPLY(a_not_found_zero, clk, rst_n, nf_out, nf_zero)

    // full table only when all slots are in use
    `ASSERT_IMPLY(a_full_count, clk, rst_n, full_out, at_depth)

endmodule

bind sorted_region_table srt_checker u_srt_checker (.*);
